// ===== rtl/arpm_pkg.sv =====
// shared types, codes and frame character helpers for the ascii register poll master
// no dependencies; every other file but arpm_if.sv refers to this package by scoped names

package arpm_pkg;

    // number of units that may ever be polled, and the units the 16-bit mask can reach
    localparam int UNIT_COUNT = 16;
    localparam logic [15:0] UNIT_LIMIT_MASK =
        (UNIT_COUNT >= 16) ? 16'hFFFF : 16'((17'd1 << UNIT_COUNT) - 17'd1);

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // action codes of an event beat
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_RESP  = 2'd2;

    // kind codes of a result beat
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_REC  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PRESENT_MASK = 2'd0;
    localparam logic [1:0] CFG_POLL_REG     = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT      = 2'd2;
    localparam logic [1:0] CFG_RETRY_LIMIT  = 2'd3;

    // reset values of the configuration registers
    localparam logic [15:0] POLL_REG_RST    = 16'd138;
    localparam logic [15:0] TIMEOUT_RST     = 16'd10;
    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd3;

    // response checks and the failure mark (999.0 degrees in tenths)
    localparam logic [7:0]  MIN_RESP_LEN = 8'd11;
    localparam logic [15:0] FAIL_READING = 16'd9990;

    // position of the final character (LF) of a request frame
    localparam logic [4:0] FRAME_LAST = 5'd16;

    // one command from front to back: optional record, then a frame or a scan-done
    typedef struct packed {
        logic        has_rec;
        logic [3:0]  rec_unit;
        logic [15:0] reading;
        logic        failed;
        logic        tail_done;
        logic [3:0]  frame_unit;
    } job_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

    // character at a given frame position for one unit and register address
    function automatic logic [7:0] frame_char(input logic [4:0] pos,
                                              input logic [3:0] unit,
                                              input logic [15:0] reg_addr);
        logic [4:0] addr;
        logic       tens;
        logic [3:0] ones;
        logic [7:0] sum;
        logic [7:0] lrc;
        logic [7:0] c;
        addr = {1'b0, unit} + 5'd1;
        tens = (addr >= 5'd10);
        ones = tens ? 4'(addr - 5'd10) : addr[3:0];
        sum  = {3'd0, tens, ones} + 8'h03 + reg_addr[15:8] + reg_addr[7:0] + 8'h01;
        lrc  = 8'd0 - sum;
        case (pos)
            5'd0:    c = 8'h3A;
            5'd1:    c = 8'h30 + {7'd0, tens};
            5'd2:    c = 8'h30 + {4'd0, ones};
            5'd3:    c = 8'h30;
            5'd4:    c = 8'h33;
            5'd5:    c = hex_char(reg_addr[15:12]);
            5'd6:    c = hex_char(reg_addr[11:8]);
            5'd7:    c = hex_char(reg_addr[7:4]);
            5'd8:    c = hex_char(reg_addr[3:0]);
            5'd9:    c = 8'h30;
            5'd10:   c = 8'h30;
            5'd11:   c = 8'h30;
            5'd12:   c = 8'h31;
            5'd13:   c = hex_char(lrc[7:4]);
            5'd14:   c = hex_char(lrc[3:0]);
            5'd15:   c = 8'h0D;
            5'd16:   c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/arpm_if.sv =====
// channel interfaces: event input, result output and configuration write
// depends on nothing but plain logic types

interface arpm_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  resp_length;
    logic [15:0] resp_value;

    modport source (output valid, action, resp_length, resp_value, input ready);
    modport sink   (input valid, action, resp_length, resp_value, output ready);
endinterface

interface arpm_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [3:0]  unit_index;
    logic [15:0] reading;
    logic        read_failed;

    modport source (output valid, kind, tx_byte, last, unit_index, reading, read_failed,
                    input ready);
    modport sink   (input valid, kind, tx_byte, last, unit_index, reading, read_failed,
                    output ready);
endinterface

interface arpm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/arpm_queue.sv =====
// small command queue between the poll front and the frame back
// depends on arpm_pkg (job_t)

module arpm_queue #(
    parameter int DEPTH = arpm_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  arpm_pkg::job_t  push_data,
    input  logic            pop,
    output arpm_pkg::job_t  head,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    arpm_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/arpm_front.sv =====
// poll front: takes event beats, runs the scan state and queues at most one command per event
// depends on arpm_pkg and arpm_evt_if

module arpm_front (
    input  logic               clk,
    input  logic               rst_n,
    arpm_evt_if.sink           events,
    input  logic [15:0]        present_mask,
    input  logic [15:0]        response_timeout,
    input  logic [3:0]         retry_limit,
    input  logic               queue_full,
    output logic               push,
    output arpm_pkg::job_t     job
);

    logic        active_reg, active_next;
    logic [3:0]  unit_reg, unit_next;
    logic [3:0]  retries_reg, retries_next;
    logic [15:0] timer_reg, timer_next;

    logic        accept;
    logic [4:0]  seek_from;
    logic [15:0] cand;
    logic [15:0] lowest;
    logic [3:0]  found_unit;
    logic        found;
    logic        retry_ok;
    logic        do_seek;
    logic        do_retry;
    logic        do_rec;
    logic [15:0] rec_reading;
    logic        rec_failed;
    logic [15:0] timer_tick;

    assign events.ready = !queue_full;
    assign accept       = events.valid && events.ready;
    assign retry_ok     = (retries_reg != 4'd0);

    // first present unit at or after the seek start
    assign seek_from = (events.action == arpm_pkg::ACT_START) ? 5'd0
                                                              : {1'b0, unit_reg} + 5'd1;
    assign cand   = present_mask & arpm_pkg::UNIT_LIMIT_MASK & (16'hFFFF << seek_from);
    assign lowest = cand & (~cand + 16'd1);
    assign found  = |cand;

    always_comb
    begin
        found_unit = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (lowest[i])
            begin
                found_unit = found_unit | 4'(i);
            end
        end
    end

    // classify the event
    always_comb
    begin
        do_seek     = 1'b0;
        do_retry    = 1'b0;
        do_rec      = 1'b0;
        rec_reading = arpm_pkg::FAIL_READING;
        rec_failed  = 1'b1;
        timer_tick  = timer_reg;
        if (accept)
        begin
            case (events.action)
                arpm_pkg::ACT_START:
                begin
                    do_seek = 1'b1;
                end
                arpm_pkg::ACT_TICK:
                begin
                    if (active_reg)
                    begin
                        if (timer_reg <= 16'd1)
                        begin
                            timer_tick = 16'd0;
                            do_retry   = retry_ok;
                            do_rec     = !retry_ok;
                            do_seek    = !retry_ok;
                        end
                        else
                        begin
                            timer_tick = timer_reg - 16'd1;
                        end
                    end
                end
                arpm_pkg::ACT_RESP:
                begin
                    if (active_reg)
                    begin
                        if (events.resp_length < arpm_pkg::MIN_RESP_LEN)
                        begin
                            do_retry = retry_ok;
                            do_rec   = !retry_ok;
                            do_seek  = !retry_ok;
                        end
                        else if (events.resp_value == 16'd0 && retry_ok)
                        begin
                            do_retry = 1'b1;
                        end
                        else
                        begin
                            do_rec      = 1'b1;
                            do_seek     = 1'b1;
                            rec_reading = events.resp_value;
                            rec_failed  = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // apply the outcome to the scan state and build the command
    always_comb
    begin
        active_next  = active_reg;
        unit_next    = unit_reg;
        retries_next = retries_reg;
        timer_next   = timer_tick;

        job.has_rec    = do_rec;
        job.rec_unit   = unit_reg;
        job.reading    = rec_reading;
        job.failed     = rec_failed;
        job.tail_done  = 1'b0;
        job.frame_unit = unit_reg;

        if (do_retry)
        begin
            retries_next = retries_reg - 4'd1;
            timer_next   = response_timeout;
        end
        else if (do_seek)
        begin
            if (found)
            begin
                active_next    = 1'b1;
                unit_next      = found_unit;
                retries_next   = retry_limit;
                timer_next     = response_timeout;
                job.frame_unit = found_unit;
            end
            else
            begin
                active_next   = 1'b0;
                timer_next    = 16'd0;
                job.tail_done = 1'b1;
            end
        end
        push = do_retry || do_seek;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            unit_reg    <= 4'd0;
            retries_reg <= 4'd0;
            timer_reg   <= 16'd0;
        end
        else
        begin
            active_reg  <= active_next;
            unit_reg    <= unit_next;
            retries_reg <= retries_next;
            timer_reg   <= timer_next;
        end
    end

endmodule

// ===== rtl/arpm_back.sv =====
// frame back: expands queued commands into result beats through an output register
// depends on arpm_pkg and arpm_res_if

module arpm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        poll_register,
    input  arpm_pkg::job_t     head,
    input  logic               queue_empty,
    output logic               pop,
    arpm_res_if.source         results
);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_REC   = 4'b0010,
        B_FRAME = 4'b0100,
        B_DONE  = 4'b1000
    } back_state_t;

    back_state_t    state_reg, state_next;
    arpm_pkg::job_t job_reg, job_next;
    logic [4:0]     pos_reg, pos_next;

    logic           ov_reg, ov_next;
    logic [1:0]     kind_reg, kind_next;
    logic [7:0]     tx_reg, tx_next;
    logic           last_reg, last_next;
    logic [3:0]     unit_reg, unit_next;
    logic [15:0]    reading_reg, reading_next;
    logic           failed_reg, failed_next;

    logic           advance;
    logic           beat_valid;
    logic           beat_end;
    back_state_t    first_state;

    assign advance = !ov_reg || results.ready;

    assign first_state = head.has_rec   ? B_REC :
                         head.tail_done ? B_DONE : B_FRAME;

    // beat of the current step
    always_comb
    begin
        beat_valid   = 1'b1;
        beat_end     = 1'b0;
        kind_next    = arpm_pkg::KIND_TX;
        tx_next      = 8'd0;
        last_next    = 1'b0;
        unit_next    = 4'd0;
        reading_next = 16'd0;
        failed_next  = 1'b0;
        case (state_reg)
            B_REC:
            begin
                kind_next    = arpm_pkg::KIND_REC;
                unit_next    = job_reg.rec_unit;
                reading_next = job_reg.reading;
                failed_next  = job_reg.failed;
            end
            B_FRAME:
            begin
                tx_next   = arpm_pkg::frame_char(pos_reg, job_reg.frame_unit, poll_register);
                unit_next = job_reg.frame_unit;
                last_next = (pos_reg == arpm_pkg::FRAME_LAST);
                beat_end  = last_next;
            end
            B_DONE:
            begin
                kind_next = arpm_pkg::KIND_DONE;
                last_next = 1'b1;
                beat_end  = 1'b1;
            end
            default:
            begin
                beat_valid = 1'b0;
                beat_end   = 1'b1;
            end
        endcase
    end

    // step sequencing
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        pos_next   = pos_reg;
        ov_next    = ov_reg;
        pop        = 1'b0;
        if (advance)
        begin
            ov_next = beat_valid;
            if (beat_end)
            begin
                pos_next = 5'd0;
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    job_next   = head;
                    state_next = first_state;
                end
                else
                begin
                    state_next = B_IDLE;
                end
            end
            else if (state_reg == B_REC)
            begin
                state_next = job_reg.tail_done ? B_DONE : B_FRAME;
                pos_next   = 5'd0;
            end
            else
            begin
                pos_next = pos_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            pos_reg   <= 5'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (advance)
        begin
            kind_reg    <= kind_next;
            tx_reg      <= tx_next;
            last_reg    <= last_next;
            unit_reg    <= unit_next;
            reading_reg <= reading_next;
            failed_reg  <= failed_next;
        end
    end

    assign results.valid       = ov_reg;
    assign results.kind        = kind_reg;
    assign results.tx_byte     = tx_reg;
    assign results.last        = last_reg;
    assign results.unit_index  = unit_reg;
    assign results.reading     = reading_reg;
    assign results.read_failed = failed_reg;

endmodule

// ===== rtl/ascii_register_poll_master.sv =====
// top level of the ascii register poll master: configuration registers, front, queue, back
// depends on arpm_pkg, arpm_if.sv, arpm_front, arpm_queue and arpm_back
//
// channel   role    payload                                              beat means
// -------   -----   --------------------------------------------------   ------------------
// events    sink    action, resp_length, resp_value                      one scan event
// results   source  kind, tx_byte, last, unit_index, reading, read_failed one result
// cfg       sink    index, data                                          one register write
//
// an event is taken whenever the command queue has room, so events may follow back to
// back; the back hands out one result beat per cycle while results is ready, so a
// polling event occupies it for its 17 frame characters, a scan-done for its done beat,
// each after a reading record where one is due; the 17-character frame through the
// output register sets the sustained rate; an idle back first pops a command into its
// job register, and queued commands follow with no gap
// a stalled results channel holds its beat in the output register and fills the queue,
// after which events.ready drops; cfg.ready is always high
// reset clears the scan state, the queue and the output valid; no clearing pass

module ascii_register_poll_master #(
    parameter int QUEUE_DEPTH = arpm_pkg::QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    arpm_evt_if.sink     events,
    arpm_res_if.source   results,
    arpm_cfg_if.sink     cfg
);

    // configuration registers, written by the user only while the block is idle, unenforced
    logic [15:0] present_mask_reg;
    logic [15:0] poll_register_reg;
    logic [15:0] timeout_reg;
    logic [3:0]  retry_limit_reg;

    // front to queue and queue to back
    arpm_pkg::job_t push_job;
    arpm_pkg::job_t head_job;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_mask_reg  <= 16'd0;
            poll_register_reg <= arpm_pkg::POLL_REG_RST;
            timeout_reg       <= arpm_pkg::TIMEOUT_RST;
            retry_limit_reg   <= arpm_pkg::RETRY_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                arpm_pkg::CFG_PRESENT_MASK: present_mask_reg  <= cfg.data;
                arpm_pkg::CFG_POLL_REG:     poll_register_reg <= cfg.data;
                arpm_pkg::CFG_TIMEOUT:      timeout_reg       <= cfg.data;
                arpm_pkg::CFG_RETRY_LIMIT:  retry_limit_reg   <= cfg.data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // front: classifies events, keeps scan state, queues at most one command per event
    arpm_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .events           (events),
        .present_mask     (present_mask_reg),
        .response_timeout (timeout_reg),
        .retry_limit      (retry_limit_reg),
        .queue_full       (queue_full),
        .push             (push),
        .job              (push_job)
    );

    // decouples event intake from frame transmission
    arpm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .head      (head_job),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // back: record, frame characters or scan-done, one beat per cycle while results is ready
    arpm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .poll_register (poll_register_reg),
        .head          (head_job),
        .queue_empty   (queue_empty),
        .pop           (pop),
        .results       (results)
    );

endmodule
